// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the dust sensor frame receiver.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define DSFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define DSFR_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DSFR_ASSERT(label, clk, rst, prop, msg)
`define DSFR_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== sv/dsfr_pkg.sv =====
// Types and constants for the dust sensor frame receiver.
// No dependencies; used by dsfr_classify and dust_sensor_frame_receiver.
package dsfr_pkg;

   localparam int unsigned FRAME_LEN = 10;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned STORE_LEN = 6;

   localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
   localparam logic [POS_W-1:0] POS_SUM_LO   = 4'd2;
   localparam logic [POS_W-1:0] POS_SUM_HI   = 4'd7;
   localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd8;
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LEN - 1);
   localparam logic [POS_W-1:0] POS_STORE_END = POS_W'(STORE_LEN);

   localparam logic [7:0] HEAD_BYTE = 8'hAA;
   localparam logic [7:0] KIND_MEAS = 8'hC0;
   localparam logic [7:0] KIND_ACK  = 8'hC5;
   localparam logic [7:0] TAIL_BYTE = 8'hAB;

   typedef enum logic [2:0] {
      STATUS_MEAS     = 3'd0,
      STATUS_ACK      = 3'd1,
      STATUS_OTHER    = 3'd2,
      STATUS_CHECKSUM = 3'd3,
      STATUS_TAIL     = 3'd4
   } status_type;

   // Stored leading bytes of a frame plus the closing checks.
   typedef struct packed {
      logic [7:0] head;
      logic [7:0] kind;
      logic [7:0] fine_lo;
      logic [7:0] fine_hi;
      logic [7:0] coarse_lo;
      logic [7:0] coarse_hi;
      logic [7:0] sum_check;
      logic [7:0] tail;
   } frame_view_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] fine;
      logic [15:0] coarse;
   } frame_result_type;

endpackage

// ===== sv/dsfr_classify.sv =====
// Frame classification for the dust sensor frame receiver.
// Depends on dsfr_pkg.
module dsfr_classify (
   input  dsfr_pkg::frame_view_type   frame,
   output dsfr_pkg::frame_result_type result
);

   always_comb begin
      result.fine   = 16'd0;
      result.coarse = 16'd0;
      if (frame.sum_check != 8'd0) begin
         // checksum wins over a bad tail
         result.status = dsfr_pkg::STATUS_CHECKSUM;
      end else if (frame.tail != dsfr_pkg::TAIL_BYTE) begin
         result.status = dsfr_pkg::STATUS_TAIL;
      end else if (frame.head == dsfr_pkg::HEAD_BYTE &&
                   frame.kind == dsfr_pkg::KIND_MEAS) begin
         result.status = dsfr_pkg::STATUS_MEAS;
         result.fine   = {frame.fine_hi, frame.fine_lo};
         result.coarse = {frame.coarse_hi, frame.coarse_lo};
      end else if (frame.head == dsfr_pkg::HEAD_BYTE &&
                   frame.kind == dsfr_pkg::KIND_ACK) begin
         result.status = dsfr_pkg::STATUS_ACK;
      end else begin
         result.status = dsfr_pkg::STATUS_OTHER;
      end
   end

endmodule

// ===== sv/dust_sensor_frame_receiver.sv =====
// Top level of the dust sensor frame receiver: byte framing and result register.
// Depends on dsfr_pkg, dsfr_classify and assert_macros.svh.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, req_rx_byte       | in
//   rsp     | rsp_valid, rsp_stall, rsp_frame_status, | out
//           | rsp_fine_dust, rsp_coarse_dust          |
//
// One byte per cycle while req_stall is low: each req transaction updates the
// frame state in the cycle it is taken; the tenth byte of a frame loads the
// result register, so the rsp transaction is offered in the next cycle.
// Reset (synchronous) returns the position and sum to zero and empties the
// result register; stored frame bytes are not cleared.
// req_stall rises only when the frame position is at the tenth byte and the result
// register still holds an untaken, stalled result; other bytes flow on.
`include "assert_macros.svh"

module dust_sensor_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_frame_status,
   output logic [15:0] rsp_fine_dust,
   output logic [15:0] rsp_coarse_dust
);

   // frame state
   logic [dsfr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [7:0]                 store_ff [dsfr_pkg::STORE_LEN];

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   dsfr_pkg::frame_result_type result_ff;

   logic                       req_fire, rsp_fire, last_byte;
   dsfr_pkg::frame_view_type   view;
   dsfr_pkg::frame_result_type result;

   // position 9 or beyond closes the frame
   assign last_byte = (pos_ff >= dsfr_pkg::POS_LAST);
   assign req_stall = last_byte && rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;

   // running sum: cleared on byte 0, accumulates bytes 2..7, XOR with byte 8
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (req_fire) begin
         if (last_byte) begin
            pos_in = dsfr_pkg::POS_FIRST;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == dsfr_pkg::POS_FIRST) begin
               sum_in = 8'd0;
            end else if (pos_ff >= dsfr_pkg::POS_SUM_LO &&
                         pos_ff <= dsfr_pkg::POS_SUM_HI) begin
               sum_in = sum_ff + req_rx_byte;
            end else if (pos_ff == dsfr_pkg::POS_CHECKSUM) begin
               sum_in = sum_ff ^ req_rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= dsfr_pkg::POS_FIRST;
         sum_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // leading bytes 0..5 kept for classification and readings
   always_ff @(posedge clock) begin
      if (req_fire && pos_ff < dsfr_pkg::POS_STORE_END) begin
         store_ff[pos_ff[2:0]] <= req_rx_byte;
      end
   end

   assign view.head      = store_ff[0];
   assign view.kind      = store_ff[1];
   assign view.fine_lo   = store_ff[2];
   assign view.fine_hi   = store_ff[3];
   assign view.coarse_lo = store_ff[4];
   assign view.coarse_hi = store_ff[5];
   assign view.sum_check = sum_ff;
   assign view.tail      = req_rx_byte;

   dsfr_classify u_classify (
      .frame  (view),
      .result (result)
   );

   // result register: loaded on the closing byte, freed when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && last_byte) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = result_ff.status;
   assign rsp_fine_dust    = result_ff.fine;
   assign rsp_coarse_dust  = result_ff.coarse;

   `DSFR_NEVER(a_pos_range, clock, reset, pos_ff > dsfr_pkg::POS_LAST, "byte position past frame end")
   `DSFR_ASSERT(a_close_loads, clock, reset, req_fire && last_byte |=> rsp_valid_ff && pos_ff == dsfr_pkg::POS_FIRST, "closing byte did not load result")
   `DSFR_ASSERT(a_rise_on_close, clock, reset, $rose(rsp_valid_ff) |-> $past(pos_ff) == dsfr_pkg::POS_LAST, "result raised away from frame end")
   `DSFR_ASSERT(a_zero_readings, clock, reset, rsp_valid_ff && result_ff.status != dsfr_pkg::STATUS_MEAS |-> result_ff.fine == 16'd0 && result_ff.coarse == 16'd0, "readings set on non-measurement frame")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for dust_sensor_frame_receiver: byte stream in, frame verdicts out.
// Depends on dsfr_pkg and the RTL of the block; no files, no arguments.
// Directed frames from a table, then random frames checked by a built-in frame predictor.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 900;   // random stream length, in bytes
   localparam int IDLE_PCT     = 30;    // idle share per side, in percent
   localparam int HOLD_LEN     = 120;   // long receiver hold-off, in cycles
   localparam int DRAIN_WAIT   = 20;    // settle time after the last result
   localparam int CYCLE_LIMIT  = 60000; // watchdog
   localparam int MAX_REPORTS  = 10;

   localparam dsfr_pkg::frame_result_type NO_RESULT = '0;

   // Directed frame: ten bytes, byte 0 in the top octet.
   typedef struct {
      logic [79:0]                bytes;
      bit                         typed;
      dsfr_pkg::frame_result_type result;
   } directed_frame_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_frame_status;
   logic [15:0] rsp_fine_dust;
   logic [15:0] rsp_coarse_dust;

   // Predictor state: mirrors the framing of the block.
   logic [dsfr_pkg::POS_W-1:0] frame_pos = dsfr_pkg::POS_FIRST;
   logic [7:0]                 frame_sum = 8'h00;
   logic [7:0]                 frame_head [dsfr_pkg::STORE_LEN];

   dsfr_pkg::frame_result_type expected_frames [$];

   int  cycle_count  = 0;
   int  mismatches   = 0;
   int  bytes_sent   = 0;
   int  frames_taken = 0;
   int  status_count [5];
   bit  quiet        = 1'b0;   // both sides run without idling while set
   int  hold_ticket  = 0;      // bumped by the stimulus to ask for a long hold-off
   int  hold_served  = 0;
   int  hold_left    = 0;

   directed_frame_type directed_frames [8];

   dust_sensor_frame_receiver i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_fine_dust    (rsp_fine_dust),
      .rsp_coarse_dust  (rsp_coarse_dust)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frame results outstanding",
                  cycle_count, expected_frames.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Predictor: advance the frame state by one byte. On the tenth byte the
   // frame closes and closed is set with the verdict in res. The checksum is
   // judged before the tail, so a frame wrong in both counts as a checksum error.
   task automatic track_byte(input logic [7:0] b, output bit closed,
                             output dsfr_pkg::frame_result_type res);
      res    = NO_RESULT;
      closed = 1'b0;
      if (frame_pos < dsfr_pkg::POS_LAST) begin
         if (frame_pos < dsfr_pkg::POS_STORE_END)
            frame_head[frame_pos[2:0]] = b;
         if (frame_pos == dsfr_pkg::POS_FIRST)
            frame_sum = 8'h00;
         else if (frame_pos >= dsfr_pkg::POS_SUM_LO && frame_pos <= dsfr_pkg::POS_SUM_HI)
            frame_sum = frame_sum + b;
         else if (frame_pos == dsfr_pkg::POS_CHECKSUM)
            frame_sum = frame_sum ^ b;   // zero from here on means a good sum
         frame_pos = frame_pos + 1'b1;
      end else begin
         // Final byte, or a position past it: close and start over.
         frame_pos = dsfr_pkg::POS_FIRST;
         closed    = 1'b1;
         if (frame_sum != 8'h00)
            res.status = dsfr_pkg::STATUS_CHECKSUM;
         else if (b != dsfr_pkg::TAIL_BYTE)
            res.status = dsfr_pkg::STATUS_TAIL;
         else if (frame_head[0] == dsfr_pkg::HEAD_BYTE &&
                  frame_head[1] == dsfr_pkg::KIND_MEAS) begin
            res.status = dsfr_pkg::STATUS_MEAS;
            res.fine   = {frame_head[3], frame_head[2]};
            res.coarse = {frame_head[5], frame_head[4]};
         end else if (frame_head[0] == dsfr_pkg::HEAD_BYTE &&
                      frame_head[1] == dsfr_pkg::KIND_ACK)
            res.status = dsfr_pkg::STATUS_ACK;
         else
            res.status = dsfr_pkg::STATUS_OTHER;
      end
   endtask

   // Offer one byte as a req transaction and wait for it to be taken.
   // Called right after a rising edge; the byte is predicted on acceptance.
   // A typed result, where given, replaces the predicted one.
   task automatic offer_byte(input logic [7:0] b, input bit typed,
                             input dsfr_pkg::frame_result_type typed_res);
      bit                         closed;
      dsfr_pkg::frame_result_type res;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      bytes_sent++;
      track_byte(b, closed, res);
      if (closed)
         expected_frames.push_back(typed ? typed_res : res);
   endtask

   // Payload byte, leaning on the extremes now and then.
   function automatic logic [7:0] payload_byte();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0)
         return 8'h00;
      if (pick == 1)
         return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // One random frame: mostly well formed, some with a wrong head or kind byte,
   // a broken checksum or tail, and some bursts of stray bytes that throw the framing
   // out of step. Any frame but a burst first tops up any partial frame with random bytes.
   task automatic send_random_frame();
      logic [7:0] frm [10];
      logic [7:0] sum;
      int         pick;
      int         i;
      pick   = $urandom_range(99);
      frm[0] = dsfr_pkg::HEAD_BYTE;
      frm[1] = dsfr_pkg::KIND_MEAS;
      sum    = 8'h00;
      for (i = 2; i < 8; i++) begin
         frm[i] = payload_byte();
         sum    = sum + frm[i];
      end
      frm[8] = sum;
      frm[9] = dsfr_pkg::TAIL_BYTE;
      if (pick >= 92) begin
         for (i = $urandom_range(1, 9); i > 0; i--)
            offer_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
         return;
      end
      if (pick >= 40 && pick < 60)
         frm[1] = dsfr_pkg::KIND_ACK;
      else if (pick >= 60 && pick < 70) begin
         if ($urandom_range(1))
            frm[1] = 8'($urandom_range(255));
         else
            frm[0] = 8'($urandom_range(255));
      end else if (pick >= 70 && pick < 82) begin
         frm[8] = sum ^ 8'($urandom_range(1, 255));
         if ($urandom_range(1))
            frm[9] = 8'($urandom_range(255));
      end else if (pick >= 82)
         frm[9] = dsfr_pkg::TAIL_BYTE ^ 8'($urandom_range(1, 255));
      while (frame_pos != dsfr_pkg::POS_FIRST)
         offer_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
      for (i = 0; i < 10; i++)
         offer_byte(frm[i], 1'b0, NO_RESULT);
   endtask

   // Compare one rsp transaction with the oldest expected frame result.
   task automatic take_result();
      dsfr_pkg::frame_result_type want;
      if (expected_frames.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("unexpected result: status %0d fine %h coarse %h",
                     rsp_frame_status, rsp_fine_dust, rsp_coarse_dust);
         return;
      end
      want = expected_frames.pop_front();
      frames_taken++;
      if (want.status <= dsfr_pkg::STATUS_TAIL)
         status_count[want.status]++;
      if (rsp_frame_status !== want.status || rsp_fine_dust !== want.fine ||
          rsp_coarse_dust !== want.coarse) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display({"frame %0d mismatch: status exp %0d got %0d, ",
                      "fine exp %h got %h, coarse exp %h got %h"},
                     frames_taken, want.status, rsp_frame_status, want.fine,
                     rsp_fine_dust, want.coarse, rsp_coarse_dust);
      end
   endtask

   // Receiver: checks each rsp transaction and drives rsp_stall. A long
   // hold-off is counted here once the stimulus asks for one.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         take_result();
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left   = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // Stimulus
   initial begin
      int j;
      int frame_no;

      foreach (status_count[i])
         status_count[i] = 0;

      // Directed frames. Typed results only where they are obvious.
      directed_frames[0] = '{80'hAA_C0_FF_FF_00_00_00_00_FE_AB, 1'b1,
                             '{dsfr_pkg::STATUS_MEAS, 16'hFFFF, 16'h0000}};
      directed_frames[1] = '{80'hAA_C0_00_00_FF_FF_01_00_FF_AB, 1'b1,
                             '{dsfr_pkg::STATUS_MEAS, 16'h0000, 16'hFFFF}};
      directed_frames[2] = '{80'hAA_C5_00_00_00_00_00_00_00_AB, 1'b1,
                             '{dsfr_pkg::STATUS_ACK, 16'h0000, 16'h0000}};
      // acknowledge with a payload: readings must still come out as zero
      directed_frames[3] = '{80'hAA_C5_12_34_56_78_9A_BC_6A_AB, 1'b0, NO_RESULT};
      directed_frames[4] = '{80'h00_00_00_00_00_00_00_00_00_AB, 1'b1,
                             '{dsfr_pkg::STATUS_OTHER, 16'h0000, 16'h0000}};
      directed_frames[5] = '{80'hAA_C0_00_00_00_00_00_00_01_AB, 1'b1,
                             '{dsfr_pkg::STATUS_CHECKSUM, 16'h0000, 16'h0000}};
      // checksum and tail both wrong: checksum wins
      directed_frames[6] = '{80'hAA_C0_00_00_00_00_00_00_01_00, 1'b1,
                             '{dsfr_pkg::STATUS_CHECKSUM, 16'h0000, 16'h0000}};
      directed_frames[7] = '{80'hAA_C0_00_00_00_00_00_00_00_AA, 1'b1,
                             '{dsfr_pkg::STATUS_TAIL, 16'h0000, 16'h0000}};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_frames[i])
         for (j = 0; j < 10; j++)
            offer_byte(directed_frames[i].bytes[79 - 8*j -: 8],
                       directed_frames[i].typed && j == 9, directed_frames[i].result);

      // Random part, with a long receiver hold-off, a stretch without
      // idling and a pause for the block to drain along the way.
      frame_no = 0;
      while (bytes_sent < 80 + RANDOM_BYTES) begin
         if (frame_no == 15)
            hold_ticket <= hold_ticket + 1;
         if (frame_no == 35)
            quiet <= 1'b1;
         if (frame_no == 55)
            quiet <= 1'b0;
         if (frame_no == 65) begin
            req_valid <= 1'b0;
            do
               @(posedge clock);
            while (expected_frames.size() != 0);
         end
         send_random_frame();
         frame_no++;
      end

      req_valid <= 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d bytes sent, %0d frame results checked in %0d cycles", bytes_sent,
               frames_taken, cycle_count);
      $display("verdicts: %0d measurement, %0d acknowledge, %0d other, %0d checksum, %0d tail",
               status_count[0], status_count[1], status_count[2], status_count[3],
               status_count[4]);
      if (mismatches == 0 && expected_frames.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
